[design/psg_three_tone_noise_generator_macros.svh]
// assertion macros for the checker file
`ifndef PSG_THREE_TONE_NOISE_GENERATOR_MACROS_SVH
`define PSG_THREE_TONE_NOISE_GENERATOR_MACROS_SVH

// clocked property, quiet while reset is applied
`define PSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds during reset
`define PSG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/psg_pkg.sv]
// shared types, codes and volume table of the sound generator
package psg_pkg;

    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 18;
    localparam int PHASE_W  = 18;
    localparam int STEP_W   = 12;
    localparam int BASE_W   = 18;
    localparam int LFSR_W   = 16;
    localparam int ATT_W    = 4;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 18;
    localparam int NUM_TONES = 3;

    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic signed [COUNT_W-1:0] count_t;
    typedef logic [ATT_W-1:0] att_t;

    // configuration register indexes
    localparam logic CFG_TONE_STEP  = 1'b0;
    localparam logic CFG_NOISE_BASE = 1'b1;

    // item kinds
    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // command byte high nibbles
    localparam logic [3:0] CMD_LATCH_T1 = 4'h8;
    localparam logic [3:0] CMD_ATT_T1   = 4'h9;
    localparam logic [3:0] CMD_LATCH_T2 = 4'hA;
    localparam logic [3:0] CMD_ATT_T2   = 4'hB;
    localparam logic [3:0] CMD_LATCH_T3 = 4'hC;
    localparam logic [3:0] CMD_ATT_T3   = 4'hD;
    localparam logic [3:0] CMD_NOISE    = 4'hE;
    localparam logic [3:0] CMD_ATT_N    = 4'hF;

    // pending channel codes
    localparam logic [1:0] CH_NONE = 2'd0;
    localparam logic [1:0] CH_T1   = 2'd1;
    localparam logic [1:0] CH_T2   = 2'd2;
    localparam logic [1:0] CH_T3   = 2'd3;

    localparam logic [1:0] RATE_TONE3 = 2'd3;

    localparam logic [STEP_W-1:0] TONE_STEP_RESET  = 12'd5;
    localparam logic [BASE_W-1:0] NOISE_BASE_RESET = 18'd23777;
    localparam logic [LFSR_W-1:0] LFSR_RESET       = 16'h8000;
    localparam att_t              ATT_SILENT       = 4'hF;

    localparam logic [PHASE_W:0]   PHASE_ONE = 19'h10000;
    localparam logic [PHASE_W:0]   PHASE_MAX = 19'h3FFFF;
    localparam logic signed [19:0] COUNT_MIN = -20'sd131072;

    // 2 dB per step, unsigned q0.15, code 15 silent
    function automatic logic [14:0] vol_q15(input att_t code);
        logic [14:0] v;
        case (code)
            4'd0:    v = 15'd32767;
            4'd1:    v = 15'd26028;
            4'd2:    v = 15'd20675;
            4'd3:    v = 15'd16422;
            4'd4:    v = 15'd13045;
            4'd5:    v = 15'd10362;
            4'd6:    v = 15'd8231;
            4'd7:    v = 15'd6538;
            4'd8:    v = 15'd5193;
            4'd9:    v = 15'd4125;
            4'd10:   v = 15'd3277;
            4'd11:   v = 15'd2603;
            4'd12:   v = 15'd2067;
            4'd13:   v = 15'd1642;
            4'd14:   v = 15'd1304;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

[design/psg_three_tone_noise_generator.sv]
// three tone plus noise sound generator with valid/stall channels
// Each beat is a command byte (mode 0, no sample out) or a tick (mode 1,
// one signed q1.15 sample out). One beat is accepted every clock unless
// in_stall is high; the input register feeds the tone, noise and mixing
// logic that loads a tick's sample into the sample register.
// A stalled sample holds the input register, which in turn
// stalls the input only when a tick is waiting behind the held sample.
// Configuration writes are taken at any time but are meant for idle.
module psg_three_tone_noise_generator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [psg_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [7:0]                    cmd_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [psg_pkg::SAMPLE_W-1:0] sample
);
    import psg_pkg::*;

    logic [STEP_W-1:0] tone_step_reg;
    logic [BASE_W-1:0] noise_base_reg;

    logic       s1_valid_reg;
    logic       s1_mode_reg;
    logic [7:0] s1_byte_reg;

    logic                 out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;

    period_t     period_latch_reg, period_latch_next;
    logic [1:0]  pending_reg, pending_next;
    period_t     tone_period_reg [NUM_TONES];
    period_t     tone_period_next [NUM_TONES];
    count_t      tone_count_reg [NUM_TONES];
    count_t      tone_count_next [NUM_TONES];
    logic [NUM_TONES-1:0] tone_pol_reg, tone_pol_next;
    att_t        att_reg [NUM_TONES+1];
    att_t        att_next [NUM_TONES+1];
    logic        noise_white_reg, noise_white_next;
    logic [1:0]  noise_rate_reg, noise_rate_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic        noise_pol_reg, noise_pol_next;

    logic out_free;
    logic s1_adv;
    logic in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    // a command never needs the sample register
    assign s1_adv    = s1_valid_reg && (out_free || (s1_mode_reg == MODE_CMD));
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_step_reg  <= TONE_STEP_RESET;
            noise_base_reg <= NOISE_BASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TONE_STEP:  tone_step_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_NOISE_BASE: noise_base_reg <= cfg_wdata[BASE_W-1:0];
                default:        tone_step_reg  <= tone_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept || s1_adv)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= cmd_byte;
        end
    end

    always_comb
    begin
        logic signed [19:0] c;
        logic [NUM_TONES-1:0] flip;
        logic [BASE_W-1:0] inc;
        logic [PHASE_W:0]  p;
        logic noise_adv;
        logic fb;
        logic signed [SAMPLE_W-1:0] acc;
        logic signed [SAMPLE_W-1:0] term;
        logic [14:0] lvl;
        logic pos;

        period_latch_next = period_latch_reg;
        pending_next      = pending_reg;
        tone_period_next  = tone_period_reg;
        tone_count_next   = tone_count_reg;
        tone_pol_next     = tone_pol_reg;
        att_next          = att_reg;
        noise_white_next  = noise_white_reg;
        noise_rate_next   = noise_rate_reg;
        phase_next        = phase_reg;
        lfsr_next         = lfsr_reg;
        noise_pol_next    = noise_pol_reg;
        flip              = '0;
        inc               = '0;
        p                 = '0;
        noise_adv         = 1'b0;
        fb                = 1'b0;
        c                 = '0;

        if (s1_mode_reg == MODE_CMD)
        begin
            unique case (s1_byte_reg[7:4])
                CMD_LATCH_T1:
                begin
                    period_latch_next = {6'd0, s1_byte_reg[3:0]};
                    pending_next      = CH_T1;
                end
                CMD_LATCH_T2:
                begin
                    period_latch_next = {6'd0, s1_byte_reg[3:0]};
                    pending_next      = CH_T2;
                end
                CMD_LATCH_T3:
                begin
                    period_latch_next = {6'd0, s1_byte_reg[3:0]};
                    pending_next      = CH_T3;
                end
                CMD_ATT_T1: att_next[0] = s1_byte_reg[3:0];
                CMD_ATT_T2: att_next[1] = s1_byte_reg[3:0];
                CMD_ATT_T3: att_next[2] = s1_byte_reg[3:0];
                CMD_ATT_N:  att_next[3] = s1_byte_reg[3:0];
                CMD_NOISE:
                begin
                    noise_white_next = s1_byte_reg[2];
                    noise_rate_next  = s1_byte_reg[1:0];
                end
                default:
                begin
                    // second byte: or in the high six bits
                    period_latch_next = period_latch_reg | {s1_byte_reg[5:0], 4'd0};
                    if (pending_reg != CH_NONE)
                    begin
                        tone_period_next[pending_reg - 2'd1] = period_latch_next;
                    end
                    pending_next = CH_NONE;
                end
            endcase
        end
        else
        begin
            for (int k = 0; k < NUM_TONES; k++)
            begin
                c = 20'(tone_count_reg[k]) - $signed({8'd0, tone_step_reg});
                if (c <= 20'sd0)
                begin
                    c = c + $signed({10'd0, tone_period_reg[k]});
                    flip[k] = 1'b1;
                    tone_pol_next[k] = !tone_pol_reg[k];
                end
                if (c < COUNT_MIN)
                begin
                    c = COUNT_MIN;
                end
                tone_count_next[k] = c[COUNT_W-1:0];
            end

            if (noise_rate_reg == RATE_TONE3)
            begin
                noise_adv = flip[2];
            end
            else
            begin
                inc = noise_base_reg >> ({1'b0, noise_rate_reg} + 3'd1);
                p   = {1'b0, phase_reg} + {1'b0, inc};
                if (p >= PHASE_ONE)
                begin
                    p = p - PHASE_ONE;
                    noise_adv = 1'b1;
                end
                if (p > PHASE_MAX)
                begin
                    p = PHASE_MAX;
                end
                phase_next = p[PHASE_W-1:0];
            end

            if (noise_adv)
            begin
                fb = noise_white_reg ? (lfsr_reg[0] ^ lfsr_reg[3]) : lfsr_reg[0];
                noise_pol_next = lfsr_reg[0];
                lfsr_next = {fb, lfsr_reg[LFSR_W-1:1]};
            end
        end

        // mix with polarities after this tick
        acc = '0;
        for (int k = 0; k <= NUM_TONES; k++)
        begin
            lvl  = vol_q15(att_reg[k]);
            term = $signed({3'd0, lvl[14:2]});
            pos  = (k < NUM_TONES) ? tone_pol_next[k] : noise_pol_next;
            acc  = pos ? (acc + term) : (acc - term);
        end
        sample_next = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_latch_reg <= '0;
            pending_reg      <= CH_NONE;
            for (int k = 0; k < NUM_TONES; k++)
            begin
                tone_period_reg[k] <= '0;
                tone_count_reg[k]  <= '0;
            end
            tone_pol_reg <= '1;
            for (int k = 0; k <= NUM_TONES; k++)
            begin
                att_reg[k] <= ATT_SILENT;
            end
            noise_white_reg <= 1'b0;
            noise_rate_reg  <= 2'd0;
            phase_reg       <= '0;
            lfsr_reg        <= LFSR_RESET;
            noise_pol_reg   <= 1'b1;
        end
        else if (s1_adv)
        begin
            period_latch_reg <= period_latch_next;
            pending_reg      <= pending_next;
            tone_period_reg  <= tone_period_next;
            tone_count_reg   <= tone_count_next;
            tone_pol_reg     <= tone_pol_next;
            att_reg          <= att_next;
            noise_white_reg  <= noise_white_next;
            noise_rate_reg   <= noise_rate_next;
            phase_reg        <= phase_next;
            lfsr_reg         <= lfsr_next;
            noise_pol_reg    <= noise_pol_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_adv && (s1_mode_reg == MODE_TICK);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_adv && (s1_mode_reg == MODE_TICK))
        begin
            sample_reg <= sample_next;
        end
    end

endmodule

[design/psg_checker.sv]
// port-level checks of the sound generator, bound to the top level
`include "psg_three_tone_noise_generator_macros.svh"

module psg_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          mode,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [psg_pkg::SAMPLE_W-1:0] sample
);
    import psg_pkg::*;

    // a held sample beat keeps its value
    `PSG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(sample), "sample changed while stalled")

    // input only backs up behind a stalled sample
    `PSG_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall, "input stall without output backpressure")

    // a new sample needs an accepted tick beat before it
    `PSG_ASSERT(a_no_phantom, !out_valid && !$past(in_valid && !in_stall && (mode == MODE_TICK)) |=> !out_valid, "sample without a tick")

endmodule

bind psg_three_tone_noise_generator psg_checker u_psg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);
